// ===== hw/rtl/ewes_pkg.sv =====
// Shared types and constants for the earliest-wake event scheduler.
// No dependencies; imported by ewes_cell and earliest_wake_event_scheduler.
package ewes_pkg;

  localparam int TIME_W         = 64;
  localparam int COMP_W         = 4;
  localparam int IDX_W          = 8;   // wide enough for the largest component count
  localparam int NUM_COMPONENTS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_APPLY,
    ST_SCAN,
    ST_FIRE,
    ST_REPORT
  } state_t;

  // Best pending entry seen so far along the chain.
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] wake;
    logic [TIME_W-1:0] order;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic              arm;
    logic              clear;
    logic [IDX_W-1:0]  sel;
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] order;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/ewes_cell.sv =====
// One component slot: pending flag, wake time and arming order, plus one
// stage of the minimum search chain. Depends on ewes_pkg.
module ewes_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  ewes_pkg::cell_cmd_t cmd,
  input  ewes_pkg::cand_t   cand_in,
  output ewes_pkg::cand_t   cand_out,
  output logic              pending,
  output logic              armed
);
  import ewes_pkg::*;

  logic [TIME_W-1:0] wake;
  logic [TIME_W-1:0] order;
  logic              hit;
  logic              own_better;
  cand_t             cand_next;

  assign hit   = (cmd.sel == IDX_W'(IDX));
  // A pending slot only re-arms on a strictly earlier tick.
  assign armed = cmd.arm && hit && (!pending || (cmd.tick < wake));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (armed) begin
      pending <= 1'b1;
    end else if (cmd.clear && hit) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (armed) begin
      wake  <= cmd.tick;
      order <= cmd.order;
    end
  end

  // Replace the incoming candidate only on a strictly smaller key, so the
  // lower index wins ties.
  assign own_better = pending &&
                      (!cand_in.valid || (wake < cand_in.wake) ||
                       ((wake == cand_in.wake) && (order < cand_in.order)));

  always_comb begin
    cand_next = cand_in;
    if (own_better) begin
      cand_next.valid = 1'b1;
      cand_next.wake  = wake;
      cand_next.order = order;
      cand_next.idx   = IDX_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out.valid <= 1'b0;
    end else begin
      cand_out.valid <= cand_next.valid;
    end
    cand_out.wake  <= cand_next.wake;
    cand_out.order <= cand_next.order;
    cand_out.idx   <= cand_next.idx;
  end

endmodule

// ===== hw/rtl/earliest_wake_event_scheduler.sv =====
// Top level of the earliest-wake event scheduler: FSM, engine counters and
// the row of component cells. Depends on ewes_pkg and ewes_cell.
//
// Usage:
//   Present an item on mode/component/tick with start high; it is taken at a
//   rising edge where busy is low. mode 0 is a wake request for a component,
//   mode 1 fires the pending component with the least (wake, arming order).
//   Each item gives exactly one result, shown on fired, fired_component,
//   current_time, idle and event_count for one cycle while done is high.
//   The receiver cannot stall; the result must be taken in that cycle.
//   Steps from the accepting edge to the done cycle:
//     wake item: clamp to engine time, apply in the cell, report.
//     step item: scan, fire, report; the minimum search walks the row of
//       cells one cell per clock.
//   One item is in work at a time; busy drops in the done cycle, so the next
//   item may be accepted while the result is shown.
//   Reset (rst, synchronous): engine time, event count and arming counter go
//   to zero and every component is not pending. Wake times and arming orders
//   hold no reset value and are read only for pending components.
module earliest_wake_event_scheduler #(
  parameter int NUM_COMPONENTS = ewes_pkg::NUM_COMPONENTS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [ewes_pkg::COMP_W-1:0] component,
  input  logic [ewes_pkg::TIME_W-1:0] tick,
  output logic                        done,
  output logic                        fired,
  output logic [ewes_pkg::COMP_W-1:0] fired_component,
  output logic [ewes_pkg::TIME_W-1:0] current_time,
  output logic                        idle,
  output logic [ewes_pkg::TIME_W-1:0] event_count
);
  import ewes_pkg::*;

  localparam int CNT_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

  state_t            state;
  state_t            state_next;
  cell_cmd_t         cmd;
  cand_t             cand [NUM_COMPONENTS+1];
  cand_t             best;
  logic [NUM_COMPONENTS-1:0] pending_vec;
  logic [NUM_COMPONENTS-1:0] armed_vec;

  logic [TIME_W-1:0] engine_time;
  logic [TIME_W-1:0] fired_total;
  logic [TIME_W-1:0] arm_counter;
  logic [CNT_W-1:0]  scan_cnt;
  logic [COMP_W-1:0] comp_q;
  logic [TIME_W-1:0] tick_q;
  logic              fired_q;
  logic [COMP_W-1:0] fcomp_q;

  assign cand[0] = '0;
  assign best    = cand[NUM_COMPONENTS];
  assign busy    = (state != ST_IDLE);

  for (genvar i = 0; i < NUM_COMPONENTS; i++) begin : g_cell
    ewes_cell #(
      .IDX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .cand_in (cand[i]),
      .cand_out(cand[i+1]),
      .pending (pending_vec[i]),
      .armed   (armed_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = mode ? ST_SCAN : ST_CLAMP;
        end
      end
      ST_CLAMP: state_next = ST_APPLY;
      ST_APPLY: begin
        cmd.arm    = 1'b1;
        cmd.sel    = IDX_W'(comp_q);
        cmd.tick   = tick_q;
        cmd.order  = arm_counter;
        state_next = ST_REPORT;
      end
      ST_SCAN: begin
        if (scan_cnt == CNT_W'(NUM_COMPONENTS - 1)) begin
          state_next = ST_FIRE;
        end
      end
      ST_FIRE: begin
        cmd.clear  = best.valid;
        cmd.sel    = best.idx;
        state_next = ST_REPORT;
      end
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control counters and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      engine_time <= '0;
      fired_total <= '0;
      arm_counter <= '0;
      scan_cnt    <= '0;
      done        <= 1'b0;
    end else begin
      done <= (state == ST_REPORT);
      case (state)
        ST_IDLE: scan_cnt <= '0;
        ST_APPLY: begin
          if (|armed_vec) begin
            arm_counter <= arm_counter + 1'b1;
          end
        end
        ST_SCAN: scan_cnt <= scan_cnt + 1'b1;
        ST_FIRE: begin
          if (best.valid) begin
            engine_time <= best.wake;
            fired_total <= fired_total + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          comp_q  <= component;
          tick_q  <= tick;
          fired_q <= 1'b0;
          fcomp_q <= '0;
        end
      end
      ST_CLAMP: begin
        // Raise a wake in the past to the current time.
        if (tick_q < engine_time) begin
          tick_q <= engine_time;
        end
      end
      ST_FIRE: begin
        fired_q <= best.valid;
        fcomp_q <= best.valid ? best.idx[COMP_W-1:0] : '0;
      end
      ST_REPORT: begin
        fired           <= fired_q;
        fired_component <= fcomp_q;
        current_time    <= engine_time;
        idle            <= ~|pending_vec;
        event_count     <= fired_total;
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/earliest_wake_event_scheduler_tb.sv =====
// Self-checking testbench for earliest_wake_event_scheduler: a directed opening
// and then random wake/step items, each result checked against a local scheduler.
// Depends on ewes_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module earliest_wake_event_scheduler_tb;

  localparam int NC = ewes_pkg::NUM_COMPONENTS;
  localparam int TW = ewes_pkg::TIME_W;
  localparam int CW = ewes_pkg::COMP_W;
  localparam int RANDOM_ITEMS = 1550;

  localparam logic MODE_WAKE = 1'b0;
  localparam logic MODE_STEP = 1'b1;
  localparam logic [TW-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic          mode;
    logic [CW-1:0] comp;
    logic [TW-1:0] tick;
  } sched_cmd_t;

  typedef struct packed {
    logic          fired;
    logic [CW-1:0] who;
    logic [TW-1:0] now;
    logic          idle;
    logic [TW-1:0] count;
  } sched_report_t;

  typedef struct packed {
    logic [TW-1:0]          now;
    logic [TW-1:0]          total;
    logic [TW-1:0]          arm_ctr;
    logic [NC-1:0]          pend;
    logic [NC-1:0][TW-1:0]  wake;
    logic [NC-1:0][TW-1:0]  order;
  } sched_state_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          mode = MODE_WAKE;
  logic [CW-1:0] component = '0;
  logic [TW-1:0] tick = '0;
  logic          busy;
  logic          done;
  logic          fired;
  logic [CW-1:0] fired_component;
  logic [TW-1:0] current_time;
  logic          idle;
  logic [TW-1:0] event_count;

  sched_cmd_t    cmd_q[$];
  sched_report_t report_q[$];
  sched_cmd_t    cur_cmd;
  sched_state_t  gen_sched;
  sched_state_t  chk_sched;
  int            err_count = 0;
  int            gap_left = 0;
  int            no_idle_left = 0;

  earliest_wake_event_scheduler dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .component       (component),
    .tick            (tick),
    .done            (done),
    .fired           (fired),
    .fired_component (fired_component),
    .current_time    (current_time),
    .idle            (idle),
    .event_count     (event_count)
  );

  always #10 clk = ~clk;

  // Apply one item to a scheduler state and return the report it produces.
  task automatic sched_step(inout sched_state_t s, input sched_cmd_t c,
                            output sched_report_t r);
    logic [TW-1:0] t;
    int            best;
    r = '0;
    best = -1;
    if (c.mode == MODE_WAKE) begin
      if (c.comp < NC) begin
        t = (c.tick < s.now) ? s.now : c.tick;
        // only an arming that brings the wake strictly earlier takes effect
        if (!(s.pend[c.comp] && t >= s.wake[c.comp])) begin
          s.pend[c.comp] = 1'b1;
          s.wake[c.comp] = t;
          s.order[c.comp] = s.arm_ctr;
          s.arm_ctr = s.arm_ctr + 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < NC; i++) begin
        if (s.pend[i] && (best < 0 || s.wake[i] < s.wake[best] ||
            (s.wake[i] == s.wake[best] && s.order[i] < s.order[best])))
          best = i;
      end
      if (best >= 0) begin
        s.pend[best] = 1'b0;
        if (s.wake[best] > s.now) s.now = s.wake[best];
        s.total = s.total + 1'b1;
        r.fired = 1'b1;
        r.who = CW'(best);
      end
    end
    r.now = s.now;
    r.idle = (s.pend == '0);
    r.count = s.total;
  endtask

  task automatic queue_cmd(input logic m, input logic [CW-1:0] c, input logic [TW-1:0] t);
    sched_cmd_t    cmd;
    sched_report_t unused;
    cmd.mode = m;
    cmd.comp = c;
    cmd.tick = t;
    sched_step(gen_sched, cmd, unused);
    cmd_q.insert(cmd_q.size(), cmd);
  endtask

  task automatic queue_step();
    queue_cmd(MODE_STEP, CW'($urandom_range(0, NC - 1)), {$urandom, $urandom});
  endtask

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input int unsigned d);
    logic [TW-1:0] sum;
    sum = a + d;
    return (sum < a) ? TICK_MAX : sum;
  endfunction

  // Pick a random item, steered by the generator-side scheduler so that most
  // wakes land near the current time and collide with pending entries.
  task automatic queue_random();
    int            roll;
    int            kind;
    int unsigned   d;
    logic [CW-1:0] c;
    logic [TW-1:0] t;
    roll = $urandom_range(0, 99);
    kind = $urandom_range(0, 99);
    c = CW'($urandom_range(0, NC - 1));
    if (roll < 42) begin
      queue_step();
    end else begin
      if (kind < 2) begin
        t = {$urandom, $urandom};
      end else if (kind < 14) begin
        d = $urandom_range(0, 300);
        t = (gen_sched.now < d) ? '0 : gen_sched.now - d;
      end else if (kind < 40 && gen_sched.pend[c]) begin
        // re-arm around the current wake: earlier, equal or later
        d = $urandom_range(0, 8);
        t = (gen_sched.wake[c] > 4) ? sat_add(gen_sched.wake[c] - 4, d) : TW'(d);
      end else begin
        t = sat_add(gen_sched.now, $urandom_range(0, 40));
      end
      queue_cmd(MODE_WAKE, c, t);
    end
  endtask

  function automatic int next_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle_left > 0) begin
      no_idle_left--;
      return 0;
    end
    if (roll < 3) no_idle_left = $urandom_range(20, 80);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  task automatic note_mismatch(input string what, input logic [TW-1:0] got,
                               input logic [TW-1:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Driver: predict on the accepting edge, then present the next item.
  always @(posedge clk) begin : drive
    sched_report_t r;
    logic          taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        sched_step(chk_sched, cur_cmd, r);
        report_q.insert(report_q.size(), r);
        gap_left = next_gap();
      end
      if (taken || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          mode <= cur_cmd.mode;
          component <= cur_cmd.comp;
          tick <= cur_cmd.tick;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    sched_report_t want;
    if (!rst && done) begin
      if (report_q.size() == 0) begin
        note_mismatch("result with nothing expected", TW'({fired, fired_component}), '0);
      end else begin
        want = report_q.pop_front();
        if (fired !== want.fired) note_mismatch("fired", TW'(fired), TW'(want.fired));
        if (fired_component !== want.who)
          note_mismatch("fired_component", TW'(fired_component), TW'(want.who));
        if (current_time !== want.now) note_mismatch("current_time", current_time, want.now);
        if (idle !== want.idle) note_mismatch("idle", TW'(idle), TW'(want.idle));
        if (event_count !== want.count) note_mismatch("event_count", event_count, want.count);
      end
    end
  end

  initial begin : run
    gen_sched = '0;
    chk_sched = '0;

    // step with nothing pending
    queue_step();
    // extremes of tick and component, equal ticks with different arming orders
    queue_cmd(MODE_WAKE, 4'd0, '0);
    queue_cmd(MODE_WAKE, 4'd15, TICK_MAX);
    queue_cmd(MODE_WAKE, 4'd7, 64'd50);
    queue_cmd(MODE_WAKE, 4'd7, 64'd60);   // later: no effect
    queue_cmd(MODE_WAKE, 4'd7, 64'd50);   // same tick: no effect
    queue_cmd(MODE_WAKE, 4'd3, 64'd50);
    queue_cmd(MODE_WAKE, 4'd9, 64'd50);
    queue_step();
    queue_step();
    queue_cmd(MODE_WAKE, 4'd7, 64'd10);   // in the past: clamp to engine time
    queue_cmd(MODE_WAKE, 4'd9, 64'd20);   // clamps to its own wake: no effect
    queue_step();
    queue_step();
    queue_step();
    queue_cmd(MODE_WAKE, 4'd15, 64'd100); // pull the far wake in
    queue_step();
    queue_step();
    queue_cmd(MODE_WAKE, 4'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_cmd(MODE_WAKE, 4'd1, 64'd120);
    queue_step();
    queue_step();

    for (int n = 0; n < RANDOM_ITEMS; n++) queue_random();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
